[rtl/core/ktai_pkg.sv]
// ----------------------------------------------------------------------------
// ktai_pkg
// Types and constants shared by the azimuth interpolator.
// ----------------------------------------------------------------------------
package ktai_pkg;

	localparam int AZIMUTH_BINS = 50;
	localparam int START_SLICES = 10;
	localparam int SLICE_COUNTS = 8;
	localparam int BEAMS        = 2;
	localparam int GATE_WIDTHS  = 8;

	localparam int BEAM_STRIDE = START_SLICES * START_SLICES;
	localparam int BIN_STRIDE  = BEAM_STRIDE * BEAMS;
	localparam int GATE_STRIDE = BIN_STRIDE * AZIMUTH_BINS;
	localparam int TABLE_DEPTH = GATE_STRIDE * GATE_WIDTHS;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);
	localparam int BIN_W       = $clog2(AZIMUTH_BINS);

	localparam logic [29:0] INV_TWO_PI_Q32 = 30'd683565276;

	localparam logic [2:0]  GATE_RESET = 3'd3;
	localparam logic [15:0] INSTR_RESET = 16'd4687;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	localparam int ROOT_STAGES = 17;

	typedef enum logic [0:0] {
		FUNC_QUERY = 1'b0,
		FUNC_WRITE = 1'b1
	} func_t;

	typedef enum logic [0:0] {
		REG_GATE_WIDTH     = 1'b0,
		REG_INSTRUMENT_KPR = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic                 write;
		logic                 err;
		logic [ADDR_W-1:0]    addr_lo;
		logic [ADDR_W-1:0]    addr_hi;
		logic [15:0]          weight;
		logic [15:0]          wdata;
	} cmd_t;

	// one root digit step: remainder/root pair
	typedef struct packed {
		logic [33:0] rem;
		logic [16:0] root;
	} rt_t;

endpackage

[rtl/core/ktai_if.sv]
// ----------------------------------------------------------------------------
// ktai_in_if / ktai_out_if / ktai_cfg_if
// Valid/ready channels of the azimuth interpolator.
// ----------------------------------------------------------------------------
interface ktai_in_if;
	logic        valid;
	logic        ready;
	logic        func;
	logic [16:0] entry_index;
	logic [15:0] entry_value;
	logic [3:0]  first_slice;
	logic [3:0]  slice_total;
	logic [1:0]  beam_select;
	logic signed [20:0] azimuth_rad;
	modport source (output valid, func, entry_index, entry_value, first_slice,
		slice_total, beam_select, azimuth_rad, input ready);
	modport sink (input valid, func, entry_index, entry_value, first_slice,
		slice_total, beam_select, azimuth_rad, output ready);
endinterface

interface ktai_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] kpr_out;
	logic        status;
	modport source (output valid, kpr_out, status, input ready);
	modport sink (input valid, kpr_out, status, output ready);
endinterface

interface ktai_cfg_if;
	logic        valid;
	logic        ready;
	logic [0:0]  index;
	logic [15:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[rtl/core/ktai_ram.sv]
// ----------------------------------------------------------------------------
// ktai_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ktai_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

[rtl/core/ktai_front.sv]
// ----------------------------------------------------------------------------
// ktai_front
// Accepts words, wraps azimuth, finds bins and table addresses (3 stages).
// ----------------------------------------------------------------------------
module ktai_front (
	input  logic                 clk,
	input  logic                 arst_n,
	ktai_in_if.sink              in_ch,
	input  logic [2:0]           gate_q,
	input  logic                 stall,
	output logic                 cmd_valid,
	output ktai_pkg::cmd_t       cmd
);
	logic        v_s1, v_s2, v_s3;
	logic        wr_s1, wr_s2;
	logic [16:0] idx_s1, idx_s2;
	logic [15:0] val_s1, val_s2;
	logic        bad_s1, bad_s2;
	logic [ktai_pkg::ADDR_W-1:0] base_s1, base_s2;
	logic signed [51:0] turns_s1;
	logic [47:0] frac_s2;
	logic        oor_s2;
	logic signed [52:0] tw;
	logic [55:0] pos;
	logic [ktai_pkg::BIN_W-1:0] lo, hi;
	logic        lo_bad;
	logic        bad_c;
	logic [ktai_pkg::ADDR_W-1:0] base_c;

	assign in_ch.ready = !stall;

	always_comb begin
		bad_c = (32'(gate_q) >= 32'(ktai_pkg::GATE_WIDTHS))
			|| (32'(in_ch.beam_select) >= 32'(ktai_pkg::BEAMS))
			|| (in_ch.slice_total == 4'd0)
			|| (32'(in_ch.slice_total) > 32'(ktai_pkg::SLICE_COUNTS))
			|| (32'(in_ch.slice_total) > 32'(ktai_pkg::START_SLICES))
			|| (32'(in_ch.first_slice) >= 32'(ktai_pkg::START_SLICES));
		base_c = ktai_pkg::ADDR_W'(
			32'(gate_q) * ktai_pkg::GATE_STRIDE
			+ 32'(in_ch.beam_select) * ktai_pkg::BEAM_STRIDE
			+ (32'(in_ch.slice_total) - 32'd1) * ktai_pkg::START_SLICES
			+ 32'(in_ch.first_slice));
	end

	always_comb begin
		tw = 53'(turns_s1);
		if (tw < 0) begin
			tw = tw + (53'sd1 <<< 48);
		end
		if (tw >= (53'sd1 <<< 48)) begin
			tw = tw - (53'sd1 <<< 48);
		end
	end

	always_comb begin
		pos = 56'(frac_s2) * 56'(ktai_pkg::AZIMUTH_BINS);
		lo_bad = (32'(pos[55:48]) >= ktai_pkg::AZIMUTH_BINS);
		lo = pos[48 +: ktai_pkg::BIN_W];
		hi = (32'(lo) == ktai_pkg::AZIMUTH_BINS - 1) ? '0 : lo + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (!stall) begin
			v_s1 <= in_ch.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (!stall) begin
			wr_s1    <= in_ch.func;
			idx_s1   <= in_ch.entry_index;
			val_s1   <= in_ch.entry_value;
			bad_s1   <= bad_c;
			base_s1  <= base_c;
			turns_s1 <= 52'(in_ch.azimuth_rad) * $signed({1'b0, ktai_pkg::INV_TWO_PI_Q32});
			wr_s2    <= wr_s1;
			idx_s2   <= idx_s1;
			val_s2   <= val_s1;
			bad_s2   <= bad_s1;
			base_s2  <= base_s1;
			oor_s2   <= (tw < 0) || (tw >= (53'sd1 <<< 48));
			frac_s2  <= tw[47:0];
			cmd.write  <= wr_s2;
			cmd.wdata  <= val_s2;
			cmd.err    <= wr_s2 ? (32'(idx_s2) >= ktai_pkg::TABLE_DEPTH)
				: (bad_s2 || oor_s2 || lo_bad);
			cmd.addr_lo <= wr_s2 ? idx_s2[ktai_pkg::ADDR_W-1:0]
				: base_s2 + ktai_pkg::ADDR_W'(32'(lo) * ktai_pkg::BIN_STRIDE);
			cmd.addr_hi <= base_s2 + ktai_pkg::ADDR_W'(32'(hi) * ktai_pkg::BIN_STRIDE);
			cmd.weight  <= pos[47:32];
		end
	end

	assign cmd_valid = v_s3;
endmodule

[rtl/core/ktai_queue.sv]
// ----------------------------------------------------------------------------
// ktai_queue
// Short command queue between the front and back halves.
// ----------------------------------------------------------------------------
module ktai_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  ktai_pkg::cmd_t push_data,
	input  logic           pop,
	output logic           not_empty,
	output logic           almost_full,
	output ktai_pkg::cmd_t head
);
	ktai_pkg::cmd_t mem_q [ktai_pkg::QUEUE_DEPTH];
	logic [ktai_pkg::QPTR_W-1:0] wp_q, rp_q;
	logic [ktai_pkg::QPTR_W:0]   cnt_q;

	assign not_empty   = cnt_q != '0;
	assign almost_full = cnt_q == (ktai_pkg::QPTR_W+1)'(ktai_pkg::QUEUE_DEPTH);
	assign head        = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop)  rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (ktai_pkg::QPTR_W+1)'(push) - (ktai_pkg::QPTR_W+1)'(pop);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		!(push && !pop && cnt_q == (ktai_pkg::QPTR_W+1)'(ktai_pkg::QUEUE_DEPTH)))
		else $error("queue overflow");
	assert property (@(posedge clk) disable iff (!arst_n) pop |-> not_empty)
		else $error("queue underflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("queue count");
endmodule

[rtl/core/ktai_back.sv]
// ----------------------------------------------------------------------------
// ktai_back
// Table access, interpolation and pipelined rounded square root.
// ----------------------------------------------------------------------------
module ktai_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	input  ktai_pkg::cmd_t cmd,
	output logic           cmd_pop,
	input  logic [15:0]    instr_q,
	ktai_out_if.source     out_ch,
	output logic           busy
);
	logic        adv;
	logic        go;
	logic        v_r1, v_r2, v_m, v_a;
	logic        err_r1, err_r2, err_m, err_a;
	logic [15:0] w_r1, w_r2;
	logic [15:0] t0, t1;
	logic [15:0] t0_r2, t1_r2;
	logic [31:0] p0_m, p1_m;
	logic [16:0] att_a;
	logic [16:0] att_c;
	logic [33:0] sq_c;
	logic [ktai_pkg::ROOT_STAGES:0] v_p;
	logic [ktai_pkg::ROOT_STAGES:0] e_p;
	logic [33:0] val_p [ktai_pkg::ROOT_STAGES];
	ktai_pkg::rt_t rr_q [ktai_pkg::ROOT_STAGES+1];
	logic [16:0] rfin;

	logic        ov_q;
	logic [15:0] ok_q;
	logic        os_q;

	assign adv  = !ov_q || out_ch.ready;
	assign go   = cmd_valid && adv;
	assign cmd_pop = go;

	ktai_ram #(.WIDTH(16), .DEPTH(ktai_pkg::TABLE_DEPTH)) u_ram_lo (
		.clk(clk), .we(go && cmd.write && !cmd.err), .waddr(cmd.addr_lo),
		.wdata(cmd.wdata), .re(go), .raddr(cmd.addr_lo), .rdata(t0));
	ktai_ram #(.WIDTH(16), .DEPTH(ktai_pkg::TABLE_DEPTH)) u_ram_hi (
		.clk(clk), .we(go && cmd.write && !cmd.err), .waddr(cmd.addr_lo),
		.wdata(cmd.wdata), .re(go), .raddr(cmd.addr_hi), .rdata(t1));

	always_comb begin
		att_c = 17'((33'(p0_m) + 33'(p1_m) + 33'd32768) >> 16);
		if (att_c > 17'd65535) att_c = 17'd65535;
		sq_c = 34'(att_a) * 34'(att_a) + 34'(instr_q) * 34'(instr_q);
	end

	// registered root pipeline, 17 digits
	always_ff @(posedge clk) begin
		if (adv) begin
			rr_q[0].rem  <= '0;
			rr_q[0].root <= '0;
			val_p[0]     <= sq_c;
			for (int k = 0; k < ktai_pkg::ROOT_STAGES; k++) begin
				logic [33:0] rm;
				logic [33:0] tr;
				rm = {rr_q[k].rem[31:0], val_p[k][33:32]};
				tr = {15'd0, rr_q[k].root, 2'b01};
				if (rm >= tr) begin
					rr_q[k+1].rem  <= rm - tr;
					rr_q[k+1].root <= {rr_q[k].root[15:0], 1'b1};
				end else begin
					rr_q[k+1].rem  <= rm;
					rr_q[k+1].root <= {rr_q[k].root[15:0], 1'b0};
				end
			end
			for (int k = 1; k < ktai_pkg::ROOT_STAGES; k++) begin
				val_p[k] <= {val_p[k-1][31:0], 2'b00};
			end
		end
	end

	always_comb begin
		rfin = rr_q[ktai_pkg::ROOT_STAGES].root;
		if (rr_q[ktai_pkg::ROOT_STAGES].rem > 34'(rr_q[ktai_pkg::ROOT_STAGES].root))
			rfin = rfin + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_r1 <= 1'b0; v_r2 <= 1'b0; v_m <= 1'b0; v_a <= 1'b0;
			v_p <= '0; ov_q <= 1'b0;
		end else if (adv) begin
			v_r1 <= go && !cmd.write;
			v_r2 <= v_r1;
			v_m  <= v_r2;
			v_a  <= v_m;
			v_p  <= {v_p[ktai_pkg::ROOT_STAGES-1:0], v_a};
			ov_q <= v_p[ktai_pkg::ROOT_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			err_r1 <= cmd.err; w_r1 <= cmd.weight;
			err_r2 <= err_r1;  w_r2 <= w_r1;
			t0_r2  <= t0;      t1_r2 <= t1;
			p0_m   <= (17'd65536 - 17'(w_r2)) * t0_r2;
			p1_m   <= w_r2 * t1_r2;
			err_m  <= err_r2;
			att_a  <= att_c;
			err_a  <= err_m;
			e_p    <= {e_p[ktai_pkg::ROOT_STAGES-1:0], err_a};
			os_q   <= e_p[ktai_pkg::ROOT_STAGES];
			ok_q   <= e_p[ktai_pkg::ROOT_STAGES] ? 16'd0
				: (rfin > 17'd65535 ? 16'hFFFF : rfin[15:0]);
		end
	end

	assign out_ch.valid   = ov_q;
	assign out_ch.kpr_out = ok_q;
	assign out_ch.status  = os_q;
	assign busy = v_r1 | v_r2 | v_m | v_a | (|v_p) | ov_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && !out_ch.ready) |=> ov_q && $stable(ok_q))
		else $error("result lost");
	assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && os_q) |-> ok_q == 16'd0)
		else $error("error value");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> cmd_valid)
		else $error("pop empty");
endmodule

[rtl/core/kpr_table_azimuth_interpolator_top.sv]
// ----------------------------------------------------------------------------
// kpr_table_azimuth_interpolator_top
// Azimuth-interpolated attitude noise lookup with instrument term.
// Pipeline: 3 front stages, 1 queue slot, 4 table/interpolate stages, a square
// sum register, 17 root digit stages and the output register; writes give no
// word. Throughput: one word per cycle; input ready drops only while the queue
// is full and the output word is held. Reset clears control and sets gate width
// 3, instrument 4687; table undefined.
// ----------------------------------------------------------------------------
module kpr_table_azimuth_interpolator_top (
	input  logic   clk,
	input  logic   arst_n,
	ktai_in_if.sink     in_ch,
	ktai_out_if.source  out_ch,
	ktai_cfg_if.sink    cfg
);
	logic [2:0]  gate_q;
	logic [15:0] instr_q;
	logic        fv, qne, qaf, pop, busy;
	ktai_pkg::cmd_t fcmd, qhead;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gate_q  <= ktai_pkg::GATE_RESET;
			instr_q <= ktai_pkg::INSTR_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				ktai_pkg::REG_GATE_WIDTH:     gate_q  <= cfg.data[2:0];
				ktai_pkg::REG_INSTRUMENT_KPR: instr_q <= cfg.data;
				default: ;
			endcase
		end
	end

	ktai_front u_front (.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .gate_q(gate_q),
		.stall(qaf && !pop), .cmd_valid(fv), .cmd(fcmd));

	ktai_queue u_queue (.clk(clk), .arst_n(arst_n), .push(fv && !(qaf && !pop)),
		.push_data(fcmd), .pop(pop), .not_empty(qne), .almost_full(qaf), .head(qhead));

	ktai_back u_back (.clk(clk), .arst_n(arst_n), .cmd_valid(qne), .cmd(qhead),
		.cmd_pop(pop), .instr_q(instr_q), .out_ch(out_ch), .busy(busy));

	assert property (@(posedge clk) disable iff (!arst_n)
		(cfg.valid && cfg.ready) |-> !busy && !qne)
		else $error("cfg while busy");
	assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> qne)
		else $error("pop without command");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && !out_ch.ready) |=> out_ch.valid)
		else $error("output dropped");
endmodule

[tb/sv/kpr_table_azimuth_interpolator_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpr_table_azimuth_interpolator_top_tb
// Self-checking bench: writes attitude table words, sends directed and random
// queries under several register settings and handshake idling phases, and
// checks every result word against an in-bench model of the interpolator.
// ----------------------------------------------------------------------------
module kpr_table_azimuth_interpolator_top_tb;

	localparam int WDOG_LIMIT = 5000;

	typedef struct {
		ktai_pkg::func_t    func;
		logic [16:0]        entry_index;
		logic [15:0]        entry_value;
		logic [3:0]         first_slice;
		logic [3:0]         slice_total;
		logic [1:0]         beam_select;
		logic signed [20:0] azimuth_rad;
	} kpr_item_t;

	typedef struct {
		logic [15:0] kpr;
		logic        status;
	} kpr_word_t;

	class kpr_scoreboard;
		logic [2:0]  gate;
		logic [15:0] instr;
		logic [15:0] att_mem [ktai_pkg::TABLE_DEPTH];
		bit          written [ktai_pkg::TABLE_DEPTH];
		kpr_word_t   expected_q [$];
		int          errors;

		function void set_reg(ktai_pkg::reg_idx_t idx, logic [15:0] data);
			if (idx == ktai_pkg::REG_GATE_WIDTH) gate = data[2:0];
			else instr = data;
		endfunction

		// bin lookup; err covers wrap overflow and bad indices
		function void locate(kpr_item_t it, output bit err, output int i0,
				output int i1, output longint w);
			longint turns, pos, lo, hi, base;
			err = 0; i0 = 0; i1 = 0; w = 0;
			turns = longint'(it.azimuth_rad) * 64'sd683565276;
			if (turns < 0) turns += 64'sd1 <<< 48;
			if (turns >= (64'sd1 <<< 48)) turns -= 64'sd1 <<< 48;
			if (turns < 0 || turns >= (64'sd1 <<< 48) || gate >= ktai_pkg::GATE_WIDTHS ||
					it.beam_select >= ktai_pkg::BEAMS || it.slice_total == 0 ||
					it.slice_total > ktai_pkg::SLICE_COUNTS ||
					it.slice_total > ktai_pkg::START_SLICES ||
					it.first_slice >= ktai_pkg::START_SLICES) begin
				err = 1;
				return;
			end
			pos = turns * ktai_pkg::AZIMUTH_BINS;
			lo = pos >>> 48;
			hi = (lo + 1 == ktai_pkg::AZIMUTH_BINS) ? 0 : lo + 1;
			w = (pos >>> 32) & 64'hFFFF;
			base = gate * ktai_pkg::GATE_STRIDE + it.beam_select * ktai_pkg::BEAM_STRIDE +
				(it.slice_total - 1) * ktai_pkg::START_SLICES + it.first_slice;
			i0 = int'(base + lo * ktai_pkg::BIN_STRIDE);
			i1 = int'(base + hi * ktai_pkg::BIN_STRIDE);
		endfunction

		function kpr_word_t interpolate(kpr_item_t it);
			kpr_word_t r;
			bit err;
			int i0, i1;
			longint w, att, sumsq, root;
			r.kpr = 0; r.status = 1;
			locate(it, err, i0, i1, w);
			if (err) return r;
			att = ((65536 - w) * att_mem[i0] + w * att_mem[i1] + 32768) >>> 16;
			if (att > 65535) att = 65535;
			sumsq = att * att + longint'(instr) * instr;
			root = 0;
			for (int b = 17; b >= 0; b--)
				if ((root | (64'd1 << b)) * (root | (64'd1 << b)) <= sumsq)
					root |= 64'd1 << b;
			if (sumsq - root * root > root) root++;
			if (root > 65535) root = 65535;
			r.kpr = root[15:0];
			r.status = 0;
			return r;
		endfunction

		function void note_input(kpr_item_t it);
			if (it.func == ktai_pkg::FUNC_WRITE) begin
				if (it.entry_index < ktai_pkg::TABLE_DEPTH) begin
					att_mem[it.entry_index] = it.entry_value;
					written[it.entry_index] = 1;
				end
			end else
				expected_q.push_back(interpolate(it));
		endfunction

		function void check_result(logic [15:0] kpr, logic status);
			kpr_word_t e;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected word kpr=%0d status=%0d", $time, kpr, status);
				errors++;
				return;
			end
			e = expected_q.pop_front();
			if (kpr !== e.kpr || status !== e.status) begin
				$display("%0t: mismatch expected kpr=%0d status=%0d actual kpr=%0d status=%0d",
					$time, e.kpr, e.status, kpr, status);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	ktai_in_if  in_ch();
	ktai_out_if out_ch();
	ktai_cfg_if cfg();

	kpr_table_azimuth_interpolator_top uut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg(cfg));

	kpr_scoreboard sb = new();
	int snd_pct, rcv_pct, hold_req, hold_left, idle_cnt, sent_cnt;

	always #6 clk = ~clk;

	initial begin
		in_ch.valid = 0; in_ch.func = ktai_pkg::FUNC_QUERY; in_ch.entry_index = 0;
		in_ch.entry_value = 0; in_ch.first_slice = 0; in_ch.slice_total = 0;
		in_ch.beam_select = 0; in_ch.azimuth_rad = 0;
		out_ch.ready = 0;
		cfg.valid = 0; cfg.index = ktai_pkg::REG_GATE_WIDTH; cfg.data = 0;
	end

	always @(negedge clk) begin
		if (hold_req > 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (hold_left > 0) begin
			out_ch.ready <= 0;
			hold_left--;
		end else
			out_ch.ready <= ($urandom_range(0, 99) >= rcv_pct);
	end

	always @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			kpr_item_t it;
			it.func = ktai_pkg::func_t'(in_ch.func);
			it.entry_index = in_ch.entry_index; it.entry_value = in_ch.entry_value;
			it.first_slice = in_ch.first_slice; it.slice_total = in_ch.slice_total;
			it.beam_select = in_ch.beam_select; it.azimuth_rad = in_ch.azimuth_rad;
			sb.note_input(it);
		end
		if (out_ch.valid && out_ch.ready)
			sb.check_result(out_ch.kpr_out, out_ch.status);
		if (cfg.valid && cfg.ready)
			sb.set_reg(ktai_pkg::reg_idx_t'(cfg.index), cfg.data);
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
				(cfg.valid && cfg.ready))
			idle_cnt = 0;
		else
			idle_cnt++;
		if (idle_cnt >= WDOG_LIMIT) begin
			$display("** kpr_table_azimuth_interpolator_top: FAILED **");
			$finish;
		end
	end

	// all driving tasks start and end just after a falling edge
	task automatic send_word(kpr_item_t it);
		while ($urandom_range(0, 99) < snd_pct) begin
			in_ch.valid <= 0;
			@(negedge clk);
		end
		in_ch.valid <= 1;
		in_ch.func <= it.func;
		in_ch.entry_index <= it.entry_index; in_ch.entry_value <= it.entry_value;
		in_ch.first_slice <= it.first_slice; in_ch.slice_total <= it.slice_total;
		in_ch.beam_select <= it.beam_select; in_ch.azimuth_rad <= it.azimuth_rad;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		sent_cnt++;
		@(negedge clk);
	endtask

	task automatic write_entry(int idx, logic [15:0] val);
		kpr_item_t it;
		it.func = ktai_pkg::FUNC_WRITE;
		it.entry_index = idx[16:0]; it.entry_value = val;
		it.first_slice = 4'($urandom); it.slice_total = 4'($urandom);
		it.beam_select = 2'($urandom); it.azimuth_rad = 21'($urandom);
		send_word(it);
	endtask

	function automatic logic [15:0] rand_value();
		case ($urandom_range(0, 9))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	// fills any unwritten table word the query would read, then sends it
	task automatic send_query(logic [3:0] first, logic [3:0] total, logic [1:0] beam,
			logic signed [20:0] az);
		kpr_item_t it;
		bit err;
		int i0, i1;
		longint w;
		it.func = ktai_pkg::FUNC_QUERY;
		it.entry_index = 17'($urandom); it.entry_value = 16'($urandom);
		it.first_slice = first; it.slice_total = total;
		it.beam_select = beam; it.azimuth_rad = az;
		sb.locate(it, err, i0, i1, w);
		if (!err) begin
			if (!sb.written[i0]) write_entry(i0, rand_value());
			if (!sb.written[i1]) write_entry(i1, rand_value());
		end
		send_word(it);
	endtask

	task automatic write_reg(ktai_pkg::reg_idx_t idx, logic [15:0] data);
		cfg.valid <= 1; cfg.index <= idx; cfg.data <= data;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		@(negedge clk);
		cfg.valid <= 0;
		@(negedge clk);
	endtask

	task automatic drain();
		in_ch.valid <= 0;
		while (sb.expected_q.size() != 0) @(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	// sends words until n more have been accepted
	task automatic random_items(int n);
		logic signed [20:0] az;
		int stop;
		stop = sent_cnt + n;
		while (sent_cnt < stop) begin
			if ($urandom_range(0, 99) < 12)
				write_entry($urandom_range(0, 131071), rand_value());
			else begin
				if ($urandom_range(0, 99) < 85)
					az = 21'(int'($urandom_range(0, 823549 + 411775)) - 411775);
				else
					az = 21'($urandom);
				if ($urandom_range(0, 99) < 85)
					send_query(4'($urandom_range(0, 9)), 4'($urandom_range(1, 8)),
						2'($urandom_range(0, 1)), az);
				else
					send_query(4'($urandom), 4'($urandom), 2'($urandom), az);
			end
		end
	endtask

	initial begin
		int gates [6] = '{3, 0, 7, 5, 3, 7};
		int instrs [6] = '{4687, 0, 65535, 12345, 777, 0};
		int snds [6] = '{0, 67, 0, 29, 0, 0};
		int rcvs [6] = '{0, 0, 67, 29, 0, 0};
		snd_pct = 0; rcv_pct = 0; hold_req = 0; hold_left = 0; idle_cnt = 0;
		sent_cnt = 0;
		sb.gate = ktai_pkg::GATE_RESET; sb.instr = ktai_pkg::INSTR_RESET; sb.errors = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed: reset settings, then field extremes and bad indices
		send_query(4'd0, 4'd1, 2'd0, 21'sd0);
		send_query(4'd9, 4'd8, 2'd1, 21'sd411774);
		send_query(4'd5, 4'd4, 2'd0, -21'sd411775);
		send_query(4'd0, 4'd1, 2'd1, 21'sd823549);
		send_query(4'd9, 4'd8, 2'd0, 21'sh100000);
		send_query(4'd0, 4'd1, 2'd0, 21'sd1048575);
		send_query(4'd3, 4'd2, 2'd0, 21'sd403540);
		send_query(4'd0, 4'd1, 2'd2, 21'sd0);
		send_query(4'd0, 4'd1, 2'd3, 21'sd0);
		send_query(4'd0, 4'd0, 2'd0, 21'sd0);
		send_query(4'd0, 4'd9, 2'd0, 21'sd0);
		send_query(4'd0, 4'd15, 2'd1, 21'sd0);
		send_query(4'd10, 4'd1, 2'd0, 21'sd0);
		send_query(4'd15, 4'd1, 2'd0, 21'sd0);
		write_entry(79999, 16'hFFFF);
		write_entry(80000, 16'h1234);
		write_entry(131071, 16'h0000);
		send_query(4'd9, 4'd8, 2'd1, -21'sd8000);
		drain();

		for (int p = 0; p < 6; p++) begin
			write_reg(ktai_pkg::REG_GATE_WIDTH, 16'(gates[p]));
			write_reg(ktai_pkg::REG_INSTRUMENT_KPR, 16'(instrs[p]));
			snd_pct = snds[p]; rcv_pct = rcvs[p];
			if (p == 4) hold_req = 300;
			random_items(p == 4 ? 180 : 270);
			drain();
		end

		if (sb.errors == 0)
			$display("** kpr_table_azimuth_interpolator_top: PASSED **");
		else
			$display("** kpr_table_azimuth_interpolator_top: FAILED **");
		$finish;
	end

endmodule
